// File: rtl/core/nabd_pkg.sv
`default_nettype none

package nabd_pkg;

    // Build constants
    localparam int MAX_OUT_WIDTH = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int DECIMATION    = 2;

    // Register field widths
    localparam int OUT_WIDTH_BITS = 11;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;

    // Column / index widths
    localparam int IDX_W = $clog2(MAX_OUT_WIDTH);
    localparam int EFF_W = IDX_W + 1;          // holds MAX_OUT_WIDTH itself
    localparam int COL_W = IDX_W + 2;          // holds a full source line length

    // Arithmetic widths
    localparam int VAL_W       = PIXEL_BITS + 1;   // one sample, sign-extended
    localparam int STORE_SUM_W = PIXEL_BITS + 3;   // pair partial sum
    localparam int CNT_W       = 2;                // pair count 0..2
    localparam int STORE_W     = STORE_SUM_W + CNT_W;
    localparam int SUM_W       = PIXEL_BITS + 4;   // block sum
    localparam int BCNT_W      = 3;                // block count 0..4
    localparam int MAG_W       = SUM_W - 1;
    localparam int PROD_W      = 2 * MAG_W;

    // Divide by 3: ceil(2^SUM_W / 3), exact for magnitudes below 2^(SUM_W-1)
    localparam logic [MAG_W-1:0] DIV3_MULT = MAG_W'(((64'd1 << SUM_W) / 3) + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OUT_WIDTH      = 2'd0,
        REG_NULL_VALUE     = 2'd1,
        REG_NEAREST_MODE   = 2'd2,
        REG_SIGNED_SAMPLES = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic sum_en;     // fold store entry with odd-line pair
        logic div_en;     // magnitude and reciprocal product
        logic load_out;   // load output register
    } nabd_cmd_t;

    typedef struct packed {
        logic odd_right;  // pending input is the right pixel of an odd-line pair
        logic out_free;   // output register can take a result
    } nabd_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/null_aware_box_decimator_core.sv
// 2x2 decimator for one band of an integer image tile, null-aware box mean or
// nearest (top-left) pick.
// Input stream: one source pixel per transfer in raster order, lines of
// 2*out_width pixels, out_width clamped to 1..1024; s_tuser marks the first pixel of a tile.
// Output stream: one pixel per 2x2 block, sent on the right pixel of each
// odd-line pair; m_tlast flags the last pixel of an output line.
// Config: cfg_we/cfg_addr/cfg_wdata write out_width, null_value, nearest_mode
// and signed_samples; write only while the block is idle.
// Flow: left pixels and even-line pixels do not stall the input. An odd-line
// right pixel goes through line store read, block sum, divide-by-count
// multiply and output load; the next input is taken after the output load.
// Result path: m_tvalid rises when the output load stores the result.
// Backpressure: the output register holds one result; input keeps flowing
// while it waits. A new result stalls in the load step (s_tready low) until
// the previous one is taken.
// Reset: config returns to out_width 1024, null 0, box mode, unsigned; column
// and line counters clear. Line store contents are not cleared: an odd line
// must follow the even line that fills it.
`default_nettype none

module null_aware_box_decimator_core
    import nabd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // source pixels
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] sample
    input  wire logic [0:0]            s_tuser,   // [0] first_of_tile
    // decimated pixels
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // [15:0] out_pixel, [25:16] out_column
    output logic                       m_tlast    // line_end
);

    nabd_cmd_t  cmd;
    nabd_stat_t stat;

    logic [PIXEL_BITS-1:0] out_pixel;
    logic [IDX_W-1:0]      out_column;

    nabd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nabd_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_sample    (s_tdata[PIXEL_BITS-1:0]),
        .in_first     (s_tuser[0]),
        .cmd          (cmd),
        .stat         (stat),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_pixel    (out_pixel),
        .out_column   (out_column),
        .out_line_end (m_tlast)
    );

    // zero pad above the column field
    assign m_tdata = {{(32 - PIXEL_BITS - IDX_W){1'b0}}, out_column, out_pixel};

endmodule

`default_nettype wire

// File: rtl/core/nabd_ram.sv
`default_nettype none

module nabd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/nabd_ctrl.sv
`default_nettype none

module nabd_ctrl
    import nabd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire nabd_stat_t stat,
    output nabd_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.accept   = s_tvalid && (state_reg == S_IDLE);
        cmd.sum_en   = (state_reg == S_SUM);
        cmd.div_en   = (state_reg == S_DIV);
        cmd.load_out = (state_reg == S_OUT) && stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && stat.odd_right) begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:  state_reg <= S_DIV;
                S_DIV:  state_reg <= S_OUT;
                S_OUT: begin
                    if (stat.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/nabd_dpath.sv
`default_nettype none

module nabd_dpath
    import nabd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [PIXEL_BITS-1:0] in_sample,
    input  wire logic                  in_first,
    input  wire nabd_cmd_t             cmd,
    output nabd_stat_t                 stat,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [PIXEL_BITS-1:0]      out_pixel,
    output logic [IDX_W-1:0]           out_column,
    output logic                       out_line_end
);

    // Config registers
    logic [OUT_WIDTH_BITS-1:0] out_width_reg;
    logic [PIXEL_BITS-1:0]     null_value_reg;
    logic                      nearest_reg;
    logic                      signed_reg;

    // Position state
    logic [COL_W-2:0]      source_column_reg;
    logic                  odd_line_reg;
    logic [PIXEL_BITS-1:0] held_left_reg;

    // Item payload
    logic [PIXEL_BITS-1:0] sample_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  line_end_reg;

    // Arithmetic pipeline
    logic signed [SUM_W-1:0] sum_reg;
    logic [BCNT_W-1:0]       cnt_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic                  m_tvalid_reg;
    logic [PIXEL_BITS-1:0] out_pixel_reg;
    logic [IDX_W-1:0]      out_column_reg;
    logic                  out_line_end_reg;

    function automatic logic signed [VAL_W-1:0] to_value(
        input logic [PIXEL_BITS-1:0] raw,
        input logic                  sgn
    );
        return {sgn & raw[PIXEL_BITS-1], raw};
    endfunction

    // Effective width and line length
    logic [EFF_W-1:0] eff_width;
    logic [COL_W-1:0] line_len;

    always_comb begin
        if (out_width_reg == '0) begin
            eff_width = EFF_W'(1);
        end else if (32'(out_width_reg) > 32'(MAX_OUT_WIDTH)) begin
            eff_width = EFF_W'(MAX_OUT_WIDTH);
        end else begin
            eff_width = EFF_W'(out_width_reg);
        end
        line_len = {eff_width, 1'b0};
    end

    // Position of the pending input pixel
    logic [COL_W-2:0] col_start, col_cur;
    logic             odd_start, odd_cur, wrap_in, wrap_out;
    logic [COL_W-1:0] col_inc;
    logic [IDX_W-1:0] idx_cur;
    logic             line_end_cur;

    always_comb begin
        col_start    = in_first ? '0 : source_column_reg;
        odd_start    = in_first ? 1'b0 : odd_line_reg;
        wrap_in      = ({1'b0, col_start} >= line_len);
        col_cur      = wrap_in ? '0 : col_start;
        odd_cur      = odd_start ^ wrap_in;
        idx_cur      = col_cur[COL_W-2:1];
        line_end_cur = ({1'b0, idx_cur} == (eff_width - EFF_W'(1)));
        col_inc      = {1'b0, col_cur} + COL_W'(1);
        wrap_out     = (col_inc >= line_len);
    end

    assign stat.odd_right = col_cur[0] & odd_cur;
    assign stat.out_free  = ~m_tvalid_reg | m_tready;

    // Even-line pair: partial sum and count, or the left sample in nearest mode
    logic                          left_ok, right_ok;
    logic signed [VAL_W-1:0]       left_val, right_val;
    logic signed [STORE_SUM_W-1:0] pair_sum;
    logic [CNT_W-1:0]              pair_cnt;
    logic [STORE_W-1:0]            ram_wdata;
    logic                          ram_we, ram_re;
    logic [STORE_W-1:0]            ram_rdata;

    always_comb begin
        left_ok   = (held_left_reg != null_value_reg);
        right_ok  = (in_sample != null_value_reg);
        left_val  = to_value(held_left_reg, signed_reg);
        right_val = to_value(in_sample, signed_reg);
        pair_sum  = (left_ok  ? {{2{left_val[VAL_W-1]}}, left_val}  : '0)
                  + (right_ok ? {{2{right_val[VAL_W-1]}}, right_val} : '0);
        pair_cnt  = CNT_W'(left_ok) + CNT_W'(right_ok);
        if (nearest_reg) begin
            ram_wdata = {CNT_W'(1), {{2{left_val[VAL_W-1]}}, left_val}};
        end else begin
            ram_wdata = {pair_cnt, pair_sum};
        end
        ram_we = cmd.accept & col_cur[0] & ~odd_cur;
        ram_re = cmd.accept & stat.odd_right;
    end

    nabd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_cur),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_cur),
        .rdata (ram_rdata)
    );

    // Odd-line completion of the block
    logic signed [STORE_SUM_W-1:0] st_sum;
    logic [CNT_W-1:0]              st_cnt;
    logic                          hl_ok, sr_ok;
    logic signed [VAL_W-1:0]       hl_val, sr_val;
    logic signed [SUM_W-1:0]       blk_sum;
    logic [BCNT_W-1:0]             blk_cnt;

    always_comb begin
        st_sum  = ram_rdata[STORE_SUM_W-1:0];
        st_cnt  = ram_rdata[STORE_W-1:STORE_SUM_W];
        hl_ok   = (held_left_reg != null_value_reg);
        sr_ok   = (sample_reg != null_value_reg);
        hl_val  = to_value(held_left_reg, signed_reg);
        sr_val  = to_value(sample_reg, signed_reg);
        if (nearest_reg) begin
            // divide by one passes the stored low bits through
            blk_sum = {st_sum[STORE_SUM_W-1], st_sum};
            blk_cnt = BCNT_W'(1);
        end else begin
            blk_sum = {st_sum[STORE_SUM_W-1], st_sum}
                    + (hl_ok ? {{3{hl_val[VAL_W-1]}}, hl_val} : '0)
                    + (sr_ok ? {{3{sr_val[VAL_W-1]}}, sr_val} : '0);
            blk_cnt = BCNT_W'(st_cnt) + BCNT_W'(hl_ok) + BCNT_W'(sr_ok);
        end
    end

    // Truncating division by the count (1..4); a count of 0 gives the null value
    logic [SUM_W-1:0]      neg_sum;
    logic [MAG_W-1:0]      quot;
    logic [MAG_W-1:0]      quot_signed;
    logic [PIXEL_BITS-1:0] div_pixel;

    always_comb begin
        neg_sum = -sum_reg;
        case (cnt_reg)
            BCNT_W'(1): quot = mag_reg;
            BCNT_W'(2): quot = mag_reg >> 1;
            BCNT_W'(3): quot = MAG_W'(prod_reg[PROD_W-1:SUM_W]);
            BCNT_W'(4): quot = mag_reg >> 2;
            default:    quot = '0;
        endcase
        quot_signed = neg_reg ? -quot : quot;
        if (cnt_reg == '0) begin
            div_pixel = null_value_reg;
        end else begin
            div_pixel = quot_signed[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_width_reg     <= OUT_WIDTH_BITS'(1024);
            null_value_reg    <= '0;
            nearest_reg       <= 1'b0;
            signed_reg        <= 1'b0;
            source_column_reg <= '0;
            odd_line_reg      <= 1'b0;
            held_left_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_OUT_WIDTH:      out_width_reg  <= cfg_wdata[OUT_WIDTH_BITS-1:0];
                    REG_NULL_VALUE:     null_value_reg <= cfg_wdata[PIXEL_BITS-1:0];
                    REG_NEAREST_MODE:   nearest_reg    <= cfg_wdata[0];
                    REG_SIGNED_SAMPLES: signed_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                source_column_reg <= wrap_out ? '0 : col_inc[COL_W-2:0];
                odd_line_reg      <= odd_cur ^ wrap_out;
                if (!col_cur[0]) begin
                    held_left_reg <= in_sample;
                end
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg   <= in_sample;
            idx_reg      <= idx_cur;
            line_end_reg <= line_end_cur;
        end
        if (cmd.sum_en) begin
            sum_reg <= blk_sum;
            cnt_reg <= blk_cnt;
        end
        if (cmd.div_en) begin
            neg_reg  <= sum_reg[SUM_W-1];
            mag_reg  <= sum_reg[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_reg[MAG_W-1:0];
            prod_reg <= (sum_reg[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_reg[MAG_W-1:0])
                        * DIV3_MULT;
        end
        if (cmd.load_out) begin
            out_pixel_reg    <= div_pixel;
            out_column_reg   <= idx_reg;
            out_line_end_reg <= line_end_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign out_pixel    = out_pixel_reg;
    assign out_column   = out_column_reg;
    assign out_line_end = out_line_end_reg;

endmodule

`default_nettype wire
